FILE: hw/rtl/tsw_pkg.sv
package tsw_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned TexDepth   = MaxWidth * MaxHeight;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FracBits   = 16;
  localparam logic [8:0]  SizeMaxW   = 9'(MaxWidth);
  localparam logic [8:0]  SizeMaxH   = 9'(MaxHeight);
  localparam logic [25:0] HalfTexel  = 26'(1 << (FracBits - 1));

  localparam logic [1:0] RegTexWidth   = 2'd0;
  localparam logic [1:0] RegTexHeight  = 2'd1;
  localparam logic [1:0] RegFilterMode = 2'd2;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] w;
  } axis_t;

  // One classified item on its way to the back end.
  typedef struct packed {
    logic        is_wr;
    logic [7:0]  x0;
    logic [7:0]  x1;
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [23:0] rgb;
  } item_t;

  function automatic logic [8:0] clamp_size(logic [8:0] s, logic [8:0] smax);
    logic [8:0] r;
    if (s == 9'd0) r = 9'd1;
    else if (s > smax) r = smax;
    else r = s;
    return r;
  endfunction

  // Low/high texel index and weight along one axis, wrapped to the size in use.
  function automatic axis_t axis_split(logic [15:0] frac, logic [8:0] size, logic bilin);
    logic [24:0] prod;
    logic [25:0] pos;
    logic [8:0]  nxt;
    logic [8:0]  szm1;
    axis_t       a;
    prod = 25'(frac) * 25'(size);
    pos  = {1'b0, prod} - HalfTexel;
    nxt  = {1'b0, pos[23:16]} + 9'd1;
    szm1 = size - 9'd1;
    if (!bilin) begin
      a.lo = prod[23:16];
      a.hi = prod[23:16];
      a.w  = 16'd0;
    end else if (pos[25]) begin
      a.lo = szm1[7:0];
      a.hi = 8'd0;
      a.w  = pos[15:0];
    end else begin
      a.lo = pos[23:16];
      a.hi = (nxt >= size) ? 8'd0 : nxt[7:0];
      a.w  = pos[15:0];
    end
    return a;
  endfunction

endpackage

FILE: hw/rtl/tsw_front.sv
module tsw_front import tsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] coord_u_i,
  input  logic [31:0] coord_v_i,
  input  logic [7:0]  texel_x_i,
  input  logic [7:0]  texel_y_i,
  input  logic [7:0]  texel_red_i,
  input  logic [7:0]  texel_green_i,
  input  logic [7:0]  texel_blue_i,
  input  logic [8:0]  width_i,
  input  logic [8:0]  height_i,
  input  logic        bilin_i,
  output logic        push_o,
  output item_t       item_o,
  input  logic        full_i
);

  logic  valid_q;
  item_t item_q, item_d;
  logic  en;
  axis_t ax, ay;

  assign en         = !valid_q || !full_i;
  assign in_stall_o = !en;
  assign push_o     = valid_q && !full_i;
  assign item_o     = item_q;

  always_comb begin
    ax = axis_split(coord_u_i[15:0], width_i, bilin_i);
    ay = axis_split(coord_v_i[15:0], height_i, bilin_i);
    item_d.is_wr = (opcode_i == OpWrite);
    item_d.rgb   = {texel_blue_i, texel_green_i, texel_red_i};
    if (opcode_i == OpWrite) begin
      item_d.x0 = texel_x_i;
      item_d.y0 = texel_y_i;
      item_d.x1 = texel_x_i;
      item_d.y1 = texel_y_i;
      item_d.tx = 16'd0;
      item_d.ty = 16'd0;
    end else begin
      item_d.x0 = ax.lo;
      item_d.x1 = ax.hi;
      item_d.tx = ax.w;
      item_d.y0 = ay.lo;
      item_d.y1 = ay.hi;
      item_d.ty = ay.w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: hw/rtl/tsw_fifo.sv
module tsw_fifo import tsw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  item_t           slot_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (PtrW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: hw/rtl/tsw_back.sv
module tsw_back import tsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o
);

  // Four copies of the store: each quad corner reads its own copy.
  logic [23:0] mem_q [4][TexDepth];
  logic [15:0] addr [4];
  logic [23:0] texel_q [4];
  logic [15:0] m_tx_q, m_ty_q, h_ty_q;
  logic        m_v_q, h_v_q, o_v_q;
  logic        en_m, en_h, en_o, pop, wr;
  logic [23:0] top_d [3], bot_d [3], top_q [3], bot_q [3];
  logic [15:0] out_d [3], out_q [3];
  logic signed [8:0]  dt, db;
  logic signed [25:0] pt, pb;
  logic signed [24:0] dv;
  logic signed [41:0] pv, vv;

  assign en_o  = !o_v_q || !out_stall_i;
  assign en_h  = !h_v_q || en_o;
  assign en_m  = !m_v_q || en_h;
  assign pop   = valid_i && en_m;
  assign pop_o = pop;
  assign wr    = pop && item_i.is_wr;

  assign addr[0] = {item_i.y0, item_i.x0};
  assign addr[1] = {item_i.y0, item_i.x1};
  assign addr[2] = {item_i.y1, item_i.x0};
  assign addr[3] = {item_i.y1, item_i.x1};

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (wr) mem_q[b][addr[b]] <= item_i.rgb;
      if (pop && !item_i.is_wr) texel_q[b] <= mem_q[b][addr[b]];
    end
    if (pop && !item_i.is_wr) begin
      m_tx_q <= item_i.tx;
      m_ty_q <= item_i.ty;
    end
  end

  // Horizontal blend, exact Q8.16.
  always_comb begin
    dt = '0;
    db = '0;
    pt = '0;
    pb = '0;
    for (int c = 0; c < 3; c++) begin
      dt = $signed({1'b0, texel_q[1][8*c +: 8]}) - $signed({1'b0, texel_q[0][8*c +: 8]});
      db = $signed({1'b0, texel_q[3][8*c +: 8]}) - $signed({1'b0, texel_q[2][8*c +: 8]});
      pt = 26'(dt) * $signed({10'd0, m_tx_q});
      pb = 26'(db) * $signed({10'd0, m_tx_q});
      top_d[c] = 24'($signed({2'b0, texel_q[0][8*c +: 8], 16'd0}) + pt);
      bot_d[c] = 24'($signed({2'b0, texel_q[2][8*c +: 8], 16'd0}) + pb);
    end
  end

  // Vertical blend, floored, then keep Q8.8.
  always_comb begin
    dv = '0;
    pv = '0;
    vv = '0;
    for (int c = 0; c < 3; c++) begin
      dv = $signed({1'b0, bot_q[c]}) - $signed({1'b0, top_q[c]});
      pv = 42'(dv) * $signed({26'd0, h_ty_q});
      vv = $signed({2'b0, top_q[c], 16'd0}) + pv;
      out_d[c] = vv[39:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      h_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (en_m) m_v_q <= pop && !item_i.is_wr;
      if (en_h) h_v_q <= m_v_q;
      if (en_o) o_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_h && m_v_q) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      h_ty_q <= m_ty_q;
    end
    if (en_o && h_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule

FILE: hw/rtl/texture_sampler_wrap_bilinear.sv
// Throughput: one item per cycle, writes and samples alike, while out_stall_i
// is low; the four texel reads come from four copies of the store, each
// written by every write. Reset clears the pipeline and queue, sets width and
// height to 256 and selects bilinear filtering; texture memory holds garbage
// until written.
module texture_sampler_wrap_bilinear import tsw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] coord_u_i,
  input  logic [31:0] coord_v_i,
  input  logic [7:0]  texel_x_i,
  input  logic [7:0]  texel_y_i,
  input  logic [7:0]  texel_red_i,
  input  logic [7:0]  texel_green_i,
  input  logic [7:0]  texel_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o
);

  logic [8:0] width_q, height_q;
  logic       mode_q;
  logic       cfg_wr;
  logic       push, full, q_valid, pop;
  item_t      f_item, q_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      mode_q   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegTexWidth:   width_q  <= pwdata[8:0];
        RegTexHeight:  height_q <= pwdata[8:0];
        RegFilterMode: mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegTexWidth:   prdata = {23'd0, width_q};
      RegTexHeight:  prdata = {23'd0, height_q};
      RegFilterMode: prdata = {31'd0, mode_q};
      default:       prdata = 32'd0;
    endcase
  end

  tsw_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .coord_u_i,
    .coord_v_i,
    .texel_x_i,
    .texel_y_i,
    .texel_red_i,
    .texel_green_i,
    .texel_blue_i,
    .width_i  (clamp_size(width_q, SizeMaxW)),
    .height_i (clamp_size(height_q, SizeMaxH)),
    .bilin_i  (mode_q),
    .push_o   (push),
    .item_o   (f_item),
    .full_i   (full)
  );

  tsw_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  tsw_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (q_valid),
    .item_i  (q_item),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .out_red_o,
    .out_green_o,
    .out_blue_o
  );

endmodule
